>>> hdl/ebpf_structural_verifier_top_assert.svh
// Assertion macros for the structural verifier.
// Used by the back end; no other dependencies.
`ifndef EBPF_STRUCTURAL_VERIFIER_TOP_ASSERT_SVH
`define EBPF_STRUCTURAL_VERIFIER_TOP_ASSERT_SVH

// Same-cycle implication under asynchronous active-low reset.
`define EBSV_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under asynchronous active-low reset.
`define EBSV_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ebsv_pkg.sv
// Shared types and constants for the structural verifier.
// No dependencies; imported by every module of the block.
`default_nettype none

package ebsv_pkg;

  localparam int unsigned LEN_W = 16;
  localparam int unsigned POS_W = 16;

  localparam logic [2:0] CLS_LD    = 3'h0;
  localparam logic [2:0] CLS_LDX   = 3'h1;
  localparam logic [2:0] CLS_ALU   = 3'h4;
  localparam logic [2:0] CLS_JMP   = 3'h5;
  localparam logic [2:0] CLS_ALU64 = 3'h7;

  localparam logic [7:0] CLS_MASK    = 8'h07;
  localparam logic [7:0] OP_MASK     = 8'hf0;
  localparam logic [7:0] SIZE_MASK   = 8'h18;
  localparam logic [7:0] OP_JA       = 8'h00;
  localparam logic [7:0] OP_CALL     = 8'h80;
  localparam logic [7:0] OP_EXIT     = 8'h90;
  localparam logic [7:0] SIZE_DW     = 8'h18;
  localparam logic [7:0] EXIT_OPCODE = 8'h95;
  localparam logic [3:0] FP_REG      = 4'd10;

  typedef enum logic [3:0] {
    RSN_OK            = 4'd0,
    RSN_BAD_LEN       = 4'd1,
    RSN_LAST_NOT_EXIT = 4'd2,
    RSN_DST_REG       = 4'd3,
    RSN_SRC_REG       = 4'd4,
    RSN_R10_WRITE     = 4'd5,
    RSN_JUMP_RANGE    = 4'd6,
    RSN_BACK_JUMP     = 4'd7,
    RSN_NO_EXIT       = 4'd8
  } reason_e;

  typedef struct packed {
    logic [7:0]         opcode;
    logic [3:0]         dst_reg;
    logic [3:0]         src_reg;
    logic signed [15:0] offset;
  } in_word_t;

  typedef struct packed {
    logic       final_res;
    logic       accepted;
    logic [3:0] reason;
  } out_word_t;

  typedef struct packed {
    reason_e            static_fault;
    logic               is_branch;
    logic               is_ja;
    logic               is_exit_insn;
    logic               is_ld_dw;
    logic               exit_code;
    logic signed [15:0] offset;
  } insn_cls_t;

endpackage

`default_nettype wire

>>> hdl/ebpf_structural_verifier_top.sv
// An accepted instruction reaches its result word through two registers: the queue
// registers the word, then the output register holds it.
// Throughput: one instruction per cycle unless out_stall_i holds a full output register.
// A two-entry queue parts front and back; a registered output holds each result word.
// Reset (rst_ni low, asynchronous): queue and output empty, program state cleared,
// prog_len set to 1.
`default_nettype none

module ebpf_structural_verifier_top #(
  parameter int MAX_INSNS = 4096,
  parameter int NUM_REGS  = 11
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [15:0]         cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire ebsv_pkg::in_word_t  in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output ebsv_pkg::out_word_t      out_word_o
);
  import ebsv_pkg::*;

  logic      push;
  logic      full;
  logic      pop;
  logic      q_valid;
  insn_cls_t cls_in;
  insn_cls_t cls_out;

  ebsv_front #(
    .NUM_REGS (NUM_REGS)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .full_i     (full),
    .push_o     (push),
    .cls_o      (cls_in)
  );

  ebsv_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cls_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (cls_out)
  );

  ebsv_back #(
    .MAX_INSNS (MAX_INSNS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_data_i    (cls_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

>>> hdl/ebsv_front.sv
// Front end: accepts instruction words and classifies them.
// Depends on ebsv_pkg; feeds ebsv_queue.
`default_nettype none

module ebsv_front #(
  parameter int NUM_REGS = 11
) (
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire ebsv_pkg::in_word_t in_word_i,
  input  wire logic               full_i,
  output logic                    push_o,
  output ebsv_pkg::insn_cls_t     cls_o
);
  import ebsv_pkg::*;

  logic [7:0] cls_bits;
  logic [7:0] op_bits;
  logic       dst_bad;
  logic       src_bad;
  logic       alu_ldx;
  logic       jmp;

  always_comb begin
    cls_bits = in_word_i.opcode & CLS_MASK;
    op_bits  = in_word_i.opcode & OP_MASK;
    dst_bad  = {1'b0, in_word_i.dst_reg} >= 5'(NUM_REGS);
    src_bad  = {1'b0, in_word_i.src_reg} >= 5'(NUM_REGS);
    alu_ldx  = (cls_bits[2:0] == CLS_ALU) || (cls_bits[2:0] == CLS_ALU64) ||
               (cls_bits[2:0] == CLS_LDX);
    jmp      = cls_bits[2:0] == CLS_JMP;

    if (dst_bad) begin
      cls_o.static_fault = RSN_DST_REG;
    end else if (src_bad) begin
      cls_o.static_fault = RSN_SRC_REG;
    end else if (alu_ldx && (in_word_i.dst_reg == FP_REG)) begin
      cls_o.static_fault = RSN_R10_WRITE;
    end else begin
      cls_o.static_fault = RSN_OK;
    end
    cls_o.is_exit_insn = jmp && (op_bits == OP_EXIT);
    cls_o.is_branch    = jmp && (op_bits != OP_EXIT) && (op_bits != OP_CALL);
    cls_o.is_ja        = op_bits == OP_JA;
    cls_o.is_ld_dw     = (cls_bits[2:0] == CLS_LD) &&
                         ((in_word_i.opcode & SIZE_MASK) == SIZE_DW);
    cls_o.exit_code    = in_word_i.opcode == EXIT_OPCODE;
    cls_o.offset       = in_word_i.offset;
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

`default_nettype wire

>>> hdl/ebsv_queue.sv
// Two-entry queue of classified words between front and back end.
// Depends on ebsv_pkg.
`default_nettype none

module ebsv_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire ebsv_pkg::insn_cls_t data_i,
  output logic                     full_o,
  input  wire logic                pop_i,
  output logic                     valid_o,
  output ebsv_pkg::insn_cls_t      data_o
);
  import ebsv_pkg::*;

  insn_cls_t  mem_q [2];
  logic       wr_q;
  logic       wr_d;
  logic       rd_q;
  logic       rd_d;
  logic [1:0] cnt_q;
  logic [1:0] cnt_d;

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i  ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_q];
  assign valid_o = cnt_q != 2'd0;
  assign full_o  = cnt_q == 2'd2;

endmodule

`default_nettype wire

>>> hdl/ebsv_back.sv
// Back end: program state, jump checks, verdict and output register.
// Depends on ebsv_pkg and the assertion macro header.
`default_nettype none

`include "ebpf_structural_verifier_top_assert.svh"

module ebsv_back #(
  parameter int MAX_INSNS = 4096
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [15:0]         cfg_wdata_i,
  input  wire logic                q_valid_i,
  input  wire ebsv_pkg::insn_cls_t q_data_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output ebsv_pkg::out_word_t      out_word_o
);
  import ebsv_pkg::*;

  logic [LEN_W-1:0] len_q;
  logic [POS_W-1:0] pos_q;
  logic [POS_W-1:0] pos_d;
  logic             skip_q;
  logic             skip_d;
  logic             exit_q;
  logic             exit_d;
  reason_e          fault_q;
  reason_e          fault_d;
  logic             out_valid_q;
  out_word_t        out_q;
  out_word_t        out_d;

  logic             len_bad;
  logic [POS_W:0]   pos_inc;
  logic             last;
  logic [17:0]      target;
  logic             range_bad;
  reason_e          verdict;

  assign pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    len_bad   = (pos_q == '0) &&
                ((len_q == '0) || ({1'b0, len_q} > 17'(MAX_INSNS)));
    pos_inc   = {1'b0, pos_q} + 17'd1;
    last      = pos_inc >= {1'b0, len_q};
    target    = {2'b00, pos_q} + 18'd1 + {{2{q_data_i.offset[15]}}, q_data_i.offset};
    range_bad = target[17] || (target[16:0] >= {1'b0, len_q});

    pos_d   = pos_q;
    skip_d  = skip_q;
    exit_d  = exit_q;
    fault_d = fault_q;
    verdict = RSN_OK;
    out_d   = '0;

    if (len_bad) begin
      out_d.final_res = 1'b1;
      out_d.reason    = RSN_BAD_LEN;
      pos_d           = '0;
      skip_d          = 1'b0;
      exit_d          = 1'b0;
      fault_d         = RSN_OK;
    end else begin
      if (skip_q) begin
        skip_d = 1'b0;
      end else if (fault_q == RSN_OK) begin
        if (q_data_i.static_fault != RSN_OK) begin
          fault_d = q_data_i.static_fault;
        end else if (q_data_i.is_branch) begin
          if (range_bad) begin
            fault_d = RSN_JUMP_RANGE;
          end else if (!q_data_i.is_ja && q_data_i.offset[15]) begin
            fault_d = RSN_BACK_JUMP;
          end
        end else if (q_data_i.is_exit_insn) begin
          exit_d = 1'b1;
        end else if (q_data_i.is_ld_dw) begin
          skip_d = 1'b1;
        end
      end

      if (!last) begin
        pos_d = pos_inc[POS_W-1:0];
      end else begin
        if (!q_data_i.exit_code) begin
          verdict = RSN_LAST_NOT_EXIT;
        end else if (fault_d != RSN_OK) begin
          verdict = fault_d;
        end else if (!exit_d) begin
          verdict = RSN_NO_EXIT;
        end
        out_d.final_res = 1'b1;
        out_d.accepted  = verdict == RSN_OK;
        out_d.reason    = verdict;
        pos_d           = '0;
        skip_d          = 1'b0;
        exit_d          = 1'b0;
        fault_d         = RSN_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= 16'd1;
      pos_q       <= '0;
      skip_q      <= 1'b0;
      exit_q      <= 1'b0;
      fault_q     <= RSN_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      if (pop_o) begin
        pos_q   <= pos_d;
        skip_q  <= skip_d;
        exit_q  <= exit_d;
        fault_q <= fault_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `EBSV_ASSERT_NOW(a_accept_ok, clk_i, rst_ni, out_valid_q && out_q.accepted, out_q.final_res && (out_q.reason == RSN_OK), "accepted verdict without final ok")
  `EBSV_ASSERT_NOW(a_nonfinal_zero, clk_i, rst_ni, out_valid_q && !out_q.final_res, !out_q.accepted && (out_q.reason == RSN_OK), "non-final word carries a verdict")
  `EBSV_ASSERT_NEXT(a_final_clears, clk_i, rst_ni, pop_o && out_d.final_res, (pos_q == '0) && !skip_q && !exit_q && (fault_q == RSN_OK), "state not cleared after final word")
  `EBSV_ASSERT_NOW(a_fault_kind, clk_i, rst_ni, fault_q != RSN_OK, (fault_q != RSN_BAD_LEN) && (fault_q != RSN_LAST_NOT_EXIT) && (fault_q != RSN_NO_EXIT), "recorded fault is not a per-instruction code")

endmodule

`default_nettype wire

>>> bench/ebpf_structural_verifier_checker.sv
// Watches both word channels and the length register of the structural verifier.
// Predicts each verdict from its own copy of the program state; depends on ebsv_pkg.
// Returns the mismatch count and the number of verdicts still owed to the top.
module ebpf_structural_verifier_checker
  import ebsv_pkg::*;
#(
  parameter int MAX_INSNS = 4096,
  parameter int NUM_REGS  = 11
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_word_t    in_word_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_word_t   out_word_i,
  output int unsigned n_errors_o,
  output int unsigned n_waiting_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0] len_q;
  int unsigned pos_q;
  bit          skip_q;
  bit          exit_q;
  reason_e     fault_q;
  out_word_t   verdicts_q[$];

  function automatic void rewind_program();
    pos_q   = 0;
    skip_q  = 1'b0;
    exit_q  = 1'b0;
    fault_q = RSN_OK;
  endfunction

  function automatic reason_e insn_fault(in_word_t w);
    logic [2:0] cls;
    logic [7:0] op;
    int         tgt;
    cls = w.opcode[2:0];
    op  = w.opcode & OP_MASK;
    if (w.dst_reg >= NUM_REGS) return RSN_DST_REG;
    if (w.src_reg >= NUM_REGS) return RSN_SRC_REG;
    if (cls == CLS_ALU || cls == CLS_ALU64 || cls == CLS_LDX) begin
      if (w.dst_reg == FP_REG) return RSN_R10_WRITE;
    end else if (cls == CLS_JMP) begin
      if (op == OP_EXIT) begin
        exit_q = 1'b1;
        return RSN_OK;
      end
      if (op == OP_CALL) return RSN_OK;
      tgt = int'(pos_q) + 1 + int'($signed(w.offset));
      if (tgt < 0 || tgt >= int'(len_q)) return RSN_JUMP_RANGE;
      if (op != OP_JA && $signed(w.offset) < 0) return RSN_BACK_JUMP;
    end else if (cls == CLS_LD && (w.opcode & SIZE_MASK) == SIZE_DW) begin
      skip_q = 1'b1;
    end
    return RSN_OK;
  endfunction

  function automatic out_word_t next_verdict(in_word_t w);
    out_word_t v;
    reason_e   r;
    v = '0;
    if (pos_q == 0 && (len_q == 0 || int'(len_q) > MAX_INSNS)) begin
      v.final_res = 1'b1;
      v.reason    = RSN_BAD_LEN;
      rewind_program();
      return v;
    end
    if (skip_q) skip_q = 1'b0;
    else if (fault_q == RSN_OK) fault_q = insn_fault(w);
    if (pos_q + 1 < len_q) begin
      pos_q++;
      return v;
    end
    if (w.opcode != EXIT_OPCODE) r = RSN_LAST_NOT_EXIT;
    else if (fault_q != RSN_OK) r = fault_q;
    else if (!exit_q) r = RSN_NO_EXIT;
    else r = RSN_OK;
    v.final_res = 1'b1;
    v.accepted  = (r == RSN_OK);
    v.reason    = r;
    rewind_program();
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      len_q = 16'd1;
      rewind_program();
      verdicts_q.delete();
      n_errors_o  = 0;
      n_waiting_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (verdicts_q.size() == 0) begin
          $error("verdict word with no instruction outstanding: %p", out_word_i);
          n_errors_o++;
        end else begin
          want = verdicts_q.pop_front();
          if (out_word_i.final_res !== want.final_res) begin
            $error("final_res: expected %0d, got %0d", want.final_res, out_word_i.final_res);
            n_errors_o++;
          end
          if (out_word_i.accepted !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, out_word_i.accepted);
            n_errors_o++;
          end
          if (out_word_i.reason !== want.reason) begin
            $error("reason: expected %0d, got %0d", want.reason, out_word_i.reason);
            n_errors_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) verdicts_q.push_back(next_verdict(in_word_i));
      if (cfg_we_i) len_q = cfg_wdata_i;
      n_waiting_o = verdicts_q.size();
    end
  end

endmodule

>>> bench/tb_ebpf_structural_verifier_top.sv
// Stimulus and verdict for ebpf_structural_verifier_top: directed programs, then
// random programs under several idle and stall mixes. Depends on ebsv_pkg, the
// block and ebpf_structural_verifier_checker, which does all the comparing.
module tb_ebpf_structural_verifier_top;
  import ebsv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAX_INSNS  = 4096;
  localparam int          NUM_REGS   = 11;
  localparam int unsigned QUIET_MAX  = 4000;
  localparam int unsigned PHASE_INSN = 120;

  localparam logic [7:0] OP_JEQ    = 8'h10;
  localparam logic [7:0] OP_MOV    = 8'hb0;
  localparam logic [7:0] LDX_W     = 8'h61;
  localparam logic [7:0] JA_OPC    = OP_JA | 8'(CLS_JMP);
  localparam logic [7:0] JEQ_OPC   = OP_JEQ | 8'(CLS_JMP);
  localparam logic [7:0] CALL_OPC  = OP_CALL | 8'(CLS_JMP);
  localparam logic [7:0] MOV64_OPC = OP_MOV | 8'(CLS_ALU64);
  localparam logic [7:0] LD_DW_OPC = SIZE_DW | 8'(CLS_LD);

  typedef enum int unsigned {
    KIND_ALU, KIND_LDX, KIND_COND, KIND_JA, KIND_CALL, KIND_EXIT, KIND_LD_DW, KIND_OTHER
  } insn_kind_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  in_word_t    in_word_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_word_t   out_word_o;

  int unsigned n_errors;
  int unsigned n_waiting;
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned quiet = 0;
  int unsigned issued;

  always #6 clk_i = ~clk_i;

  ebpf_structural_verifier_top #(
    .MAX_INSNS (MAX_INSNS),
    .NUM_REGS  (NUM_REGS)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  ebpf_structural_verifier_checker #(
    .MAX_INSNS (MAX_INSNS),
    .NUM_REGS  (NUM_REGS)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_i  (out_word_o),
    .n_errors_o  (n_errors),
    .n_waiting_o (n_waiting)
  );

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_MAX) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    issued++;
  endtask

  task automatic send_insn(logic [7:0] opc, logic [3:0] rd, logic [3:0] rs,
                           logic signed [15:0] off);
    in_word_t w;
    w.opcode  = opc;
    w.dst_reg = rd;
    w.src_reg = rs;
    w.offset  = off;
    send_word(w);
  endtask

  // drain, hold off, then write the length
  task automatic set_len(int unsigned len);
    in_valid_i <= 1'b0;
    while (n_waiting != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= 16'(len);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic in_word_t make_insn(int unsigned p, int unsigned len);
    in_word_t   w;
    insn_kind_e kind;
    logic [3:0] op;
    w = in_word_t'($urandom);
    w.dst_reg = 4'($urandom_range(FP_REG - 1));
    w.src_reg = 4'($urandom_range(FP_REG));
    if (p + 1 == len && $urandom_range(9) != 0) begin
      w.opcode = EXIT_OPCODE;
      return w;
    end
    kind = insn_kind_e'($urandom_range(KIND_OTHER));
    case (kind)
      KIND_ALU: w.opcode[2:0] = $urandom_range(1) ? CLS_ALU : CLS_ALU64;
      KIND_LDX: w.opcode[2:0] = CLS_LDX;
      KIND_COND: begin
        do op = 4'($urandom);
        while (op == OP_JA[7:4] || op == OP_CALL[7:4] || op == OP_EXIT[7:4]);
        w.opcode = {op, w.opcode[3], CLS_JMP};
        w.offset = (p + 1 < len) ? 16'($urandom_range(len - p - 2)) : '0;
      end
      KIND_JA: begin
        w.opcode = {OP_JA[7:4], w.opcode[3], CLS_JMP};
        w.offset = 16'(int'($urandom_range(len - 1)) - int'(p) - 1);
      end
      KIND_CALL:  w.opcode = {OP_CALL[7:4], w.opcode[3], CLS_JMP};
      KIND_EXIT:  w.opcode = {OP_EXIT[7:4], w.opcode[3], CLS_JMP};
      KIND_LD_DW: w.opcode = {w.opcode[7:5], SIZE_DW[4:3], CLS_LD};
      default: ;
    endcase
    if ($urandom_range(99) < 6) begin
      case ($urandom_range(3))
        0: w.dst_reg = 4'($urandom);
        1: w.src_reg = 4'($urandom);
        2: w.offset  = 16'($urandom);
        default: w.dst_reg = FP_REG;
      endcase
    end
    return w;
  endfunction

  task automatic run_program(int unsigned len);
    in_word_t w;
    bit       skip;
    skip = 1'b0;
    if (len == 0 || len > MAX_INSNS) begin
      send_word(in_word_t'($urandom));
      return;
    end
    for (int unsigned p = 0; p < len; p++) begin
      w = skip ? in_word_t'($urandom) : make_insn(p, len);
      skip = !skip && w.opcode[2:0] == CLS_LD && (w.opcode & SIZE_MASK) == SIZE_DW;
      send_word(w);
    end
  endtask

  initial begin
    int unsigned len;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    gap_pct     = 0;
    stall_pct   = 0;
    issued      = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_insn(EXIT_OPCODE, 4'd0, 4'd0, 16'sd0);
    set_len(0);
    send_insn(8'hff, 4'hf, 4'hf, 16'hffff);
    set_len(MAX_INSNS + 1);
    send_insn(EXIT_OPCODE, 4'd0, 4'd0, 16'sd0);
    set_len(16'hffff);
    send_insn(EXIT_OPCODE, 4'd0, 4'd0, 16'sd0);
    set_len(1);
    send_insn(JA_OPC, 4'd0, 4'd0, -16'sd32768);
    set_len(2);
    send_insn(MOV64_OPC, 4'd15, 4'd0, 16'sd0);
    send_insn(EXIT_OPCODE, 4'd0, 4'd0, 16'sd0);
    send_insn(MOV64_OPC, 4'd0, 4'd15, 16'sd0);
    send_insn(EXIT_OPCODE, 4'd0, 4'd0, 16'sd0);
    send_insn(LDX_W, FP_REG, 4'd1, 16'sd0);
    send_insn(EXIT_OPCODE, 4'd0, 4'd0, 16'sd0);
    send_insn(JA_OPC, 4'd0, 4'd0, 16'sd32767);
    send_insn(EXIT_OPCODE, 4'd0, 4'd0, 16'sd0);
    send_insn(LD_DW_OPC, 4'd1, 4'd0, 16'sd0);
    send_insn(EXIT_OPCODE, 4'd0, 4'd0, 16'sd0);
    send_insn(CALL_OPC, 4'd0, 4'd0, 16'sd0);
    send_insn(EXIT_OPCODE, 4'd0, 4'd0, 16'sd0);
    set_len(3);
    send_insn(MOV64_OPC, 4'd0, 4'd0, 16'sd0);
    send_insn(JEQ_OPC, 4'd0, FP_REG, -16'sd2);
    send_insn(EXIT_OPCODE, 4'd0, 4'd0, 16'sd0);
    send_insn(MOV64_OPC, 4'd9, 4'd10, 16'sd0);
    send_insn(JA_OPC, 4'd0, 4'd0, -16'sd2);
    send_insn(EXIT_OPCODE, 4'd0, 4'd0, 16'sd0);
    set_len(4);
    send_insn(MOV64_OPC, 4'd1, 4'd2, 16'sd0);
    send_insn(MOV64_OPC, 4'd3, 4'd4, 16'sd0);
    set_len(2);
    send_insn(EXIT_OPCODE, 4'd0, 4'd0, 16'sd0);

    set_len(MAX_INSNS);
    send_insn(MOV64_OPC, 4'd0, 4'd0, 16'sd0);
    set_len(2);
    send_insn(EXIT_OPCODE, 4'd0, 4'd0, 16'sd0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 52; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 52; end
        default: begin gap_pct = 17; stall_pct = 17; end
      endcase
      issued = 0;
      while (issued < PHASE_INSN) begin
        case ($urandom_range(99)) inside
          [0:2]:   len = 0;
          [3:5]:   len = $urandom_range(16'hffff, MAX_INSNS + 1);
          [6:11]:  len = $urandom_range(64, 17);
          default: len = $urandom_range(16, 1);
        endcase
        set_len(len);
        repeat ($urandom_range(3, 1)) run_program(len);
      end
    end

    in_valid_i <= 1'b0;
    stall_pct = 0;
    while (n_waiting != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
    if (n_errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/ebsv_pkg.sv
hdl/ebsv_front.sv
hdl/ebsv_queue.sv
hdl/ebsv_back.sv
hdl/ebpf_structural_verifier_top.sv
bench/ebpf_structural_verifier_checker.sv
bench/tb_ebpf_structural_verifier_top.sv
